>>> sv/ltbe_pkg.sv
package ltbe_pkg;

  localparam int STORE_DEPTH_DEF = 16384;

  localparam logic [7:0] CR_BYTE = 8'd13;
  localparam logic [7:0] LF_BYTE = 8'd10;
  localparam logic [8:0] NONE_MARK = 9'h100;

  typedef enum logic [3:0] {
    CMD_NEW     = 4'd0,
    CMD_CLOSE   = 4'd1,
    CMD_LOAD    = 4'd2,
    CMD_FINISH  = 4'd3,
    CMD_INSERT  = 4'd4,
    CMD_DELETE  = 4'd5,
    CMD_SEEK    = 4'd6,
    CMD_LINELEN = 4'd7,
    CMD_INDEXOF = 4'd8,
    CMD_COUNTS  = 4'd9
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

endpackage

>>> sv/line_text_buffer_engine.sv
// new, close, load, finish, counts and the full or range cases answer in the cycle after start
// insert shifts later bytes up, writes the byte; at the end it answers in the cycle after start
// delete shifts later bytes down; seek, line length and index of scan the text from its start
// one transaction at a time, next start taken in the result cycle; results cannot be stalled
// the text memory (one read, one write port, registered read) moves one byte per cycle
// synchronous reset empties the document and clears valid; memory contents are not cleared
module line_text_buffer_engine
  import ltbe_pkg::*;
#(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  command,
  input  logic [13:0] position,
  input  logic [7:0]  data_byte,
  input  logic [14:0] line_number,
  input  logic [13:0] column,
  output logic        result_valid,
  output logic [1:0]  status,
  output logic [13:0] value,
  output logic [13:0] total_lines,
  output logic [14:0] editor_lines,
  output logic        modified,
  output logic        document_valid
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = ((AW > 14) ? AW : 14) + 1;
  localparam int LCW = AW + 1;
  localparam logic [AW-1:0] CAP = AW'(STORE_DEPTH - 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_INS  = 6'b000010,
    S_DEL  = 6'b000100,
    S_SCAN = 6'b001000,
    S_TRD  = 6'b010000,
    S_TCAP = 6'b100000
  } state_t;

  logic [7:0] mem [STORE_DEPTH];
  logic [7:0] rdata;

  state_t state, state_next;
  logic [AW-1:0] len, len_next;
  logic [LCW-1:0] lc, lc_next;
  logic [8:0] last_ld, last_ld_next;
  logic dirty, dirty_next;
  logic valid, valid_next;
  logic last_cr, last_cr_next;
  logic strobe, strobe_next;

  logic [AW-1:0] ra, ra_next;
  logic [AW-1:0] wa, wa_next;
  logic iss, iss_next;
  logic pend, pend_next;
  logic first, first_next;
  logic seekph, seekph_next;
  logic [AW-1:0] ci, ci_next;
  logic [14:0] line, line_next;
  logic [14:0] n, n_next;
  logic [13:0] col, col_next;
  logic [AW-1:0] cnt, cnt_next;
  logic [AW-1:0] p, p_next;
  logic [7:0] byte_r, byte_r_next;
  logic [3:0] cmd_r, cmd_r_next;
  logic [7:0] dval, dval_next;
  logic [1:0] st_r, st_r_next;
  logic [13:0] val_r, val_r_next;

  logic we;
  logic [AW-1:0] wadr;
  logic [7:0] wdat;

  logic [CW-1:0] pos_ext, len_ext;
  logic [AW-1:0] pclamp;
  logic sdone, stop;
  logic [LCW-1:0] tot;

  assign busy = (state != S_IDLE);
  assign pos_ext = CW'(position);
  assign len_ext = CW'(len);
  assign pclamp = (pos_ext > len_ext) ? len : AW'(pos_ext);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wadr] <= wdat;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[ra];
  end

  always_comb begin
    state_next = state;
    len_next = len;
    lc_next = lc;
    last_ld_next = last_ld;
    dirty_next = dirty;
    valid_next = valid;
    last_cr_next = last_cr;
    strobe_next = 1'b0;
    ra_next = ra;
    wa_next = wa;
    iss_next = iss;
    pend_next = 1'b0;
    first_next = first;
    seekph_next = seekph;
    ci_next = ci;
    line_next = line;
    n_next = n;
    col_next = col;
    cnt_next = cnt;
    p_next = p;
    byte_r_next = byte_r;
    cmd_r_next = cmd_r;
    dval_next = dval;
    st_r_next = st_r;
    val_r_next = val_r;
    we = 1'b0;
    wadr = wa;
    wdat = rdata;
    sdone = 1'b0;
    stop = 1'b0;

    case (state)
      S_IDLE: begin
        if (start) begin
          st_r_next = ST_OK;
          val_r_next = '0;
          cmd_r_next = command;
          byte_r_next = data_byte;
          case (command)
            CMD_NEW, CMD_CLOSE: begin
              len_next = '0;
              lc_next = '0;
              last_ld_next = NONE_MARK;
              dirty_next = 1'b0;
              valid_next = (command == CMD_NEW);
              last_cr_next = 1'b0;
              strobe_next = 1'b1;
            end
            CMD_LOAD: begin
              strobe_next = 1'b1;
              if (data_byte != LF_BYTE) begin
                if (len >= CAP) begin
                  st_r_next = ST_FULL;
                end else begin
                  we = 1'b1;
                  wadr = len;
                  wdat = data_byte;
                  len_next = len + 1'b1;
                  if (data_byte == CR_BYTE) begin
                    lc_next = lc + 1'b1;
                  end
                  last_ld_next = {1'b0, data_byte};
                  last_cr_next = (data_byte == CR_BYTE);
                end
              end
            end
            CMD_FINISH: begin
              if (last_ld != NONE_MARK && last_ld != {1'b0, CR_BYTE}) begin
                lc_next = lc + 1'b1;
              end
              last_ld_next = NONE_MARK;
              dirty_next = 1'b0;
              valid_next = 1'b1;
              strobe_next = 1'b1;
            end
            CMD_INSERT: begin
              if (len >= CAP) begin
                st_r_next = ST_FULL;
                strobe_next = 1'b1;
              end else if (pclamp == len) begin
                we = 1'b1;
                wadr = len;
                wdat = data_byte;
                len_next = len + 1'b1;
                dirty_next = 1'b1;
                last_cr_next = (data_byte == CR_BYTE);
                strobe_next = 1'b1;
              end else begin
                p_next = pclamp;
                ra_next = len - 1'b1;
                wa_next = len;
                iss_next = 1'b1;
                state_next = S_INS;
              end
            end
            CMD_DELETE: begin
              if (pos_ext >= len_ext) begin
                st_r_next = ST_RANGE;
                strobe_next = 1'b1;
              end else begin
                p_next = AW'(pos_ext);
                ra_next = AW'(pos_ext);
                wa_next = AW'(pos_ext);
                iss_next = 1'b1;
                first_next = 1'b1;
                state_next = S_DEL;
              end
            end
            CMD_SEEK, CMD_LINELEN, CMD_INDEXOF: begin
              n_next = (line_number == 15'd0) ? 15'd1 : line_number;
              col_next = column;
              ra_next = '0;
              ci_next = '0;
              line_next = 15'd1;
              seekph_next = 1'b1;
              cnt_next = '0;
              state_next = S_SCAN;
            end
            default: begin
              strobe_next = 1'b1;
            end
          endcase
        end
      end

      S_INS: begin
        // descending copy: read one below, write it one above
        pend_next = iss;
        if (iss) begin
          if (ra == p) begin
            iss_next = 1'b0;
          end else begin
            ra_next = ra - 1'b1;
          end
        end
        if (pend) begin
          we = 1'b1;
          wadr = wa;
          wdat = rdata;
          wa_next = wa - 1'b1;
        end else if (!iss) begin
          we = 1'b1;
          wadr = p;
          wdat = byte_r;
          len_next = len + 1'b1;
          dirty_next = 1'b1;
          strobe_next = 1'b1;
          state_next = S_IDLE;
        end
      end

      S_DEL: begin
        // first read returns the deleted byte, the rest shift down
        pend_next = iss;
        if (iss) begin
          if (ra == len - 1'b1) begin
            iss_next = 1'b0;
          end else begin
            ra_next = ra + 1'b1;
          end
        end
        if (pend) begin
          if (first) begin
            dval_next = rdata;
            first_next = 1'b0;
          end else begin
            we = 1'b1;
            wadr = wa;
            wdat = rdata;
            wa_next = wa + 1'b1;
          end
        end else if (!iss) begin
          len_next = len - 1'b1;
          dirty_next = 1'b1;
          val_r_next = 14'(dval);
          if (len == AW'(1)) begin
            last_cr_next = 1'b0;
            strobe_next = 1'b1;
            state_next = S_IDLE;
          end else begin
            ra_next = len - AW'(2);
            state_next = S_TRD;
          end
        end
      end

      S_TRD: begin
        state_next = S_TCAP;
      end

      S_TCAP: begin
        last_cr_next = (rdata == CR_BYTE);
        strobe_next = 1'b1;
        state_next = S_IDLE;
      end

      S_SCAN: begin
        ra_next = ra + 1'b1;
        pend_next = 1'b1;
        if (pend) begin
          sdone = !seekph || (ci >= len) || (line >= n);
          if (!sdone) begin
            if (rdata == CR_BYTE) begin
              line_next = line + 1'b1;
            end
            ci_next = ci + 1'b1;
          end else begin
            seekph_next = 1'b0;
            stop = (cmd_r == CMD_SEEK) || (ci >= len) || (rdata == CR_BYTE) ||
                   ((cmd_r == CMD_INDEXOF) && (col == 14'd0));
            if (stop) begin
              val_r_next = (cmd_r == CMD_LINELEN) ? 14'(cnt) : 14'(ci);
              strobe_next = 1'b1;
              state_next = S_IDLE;
            end else begin
              cnt_next = cnt + 1'b1;
              col_next = col - 1'b1;
              ci_next = ci + 1'b1;
            end
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      len <= '0;
      lc <= '0;
      last_ld <= NONE_MARK;
      dirty <= 1'b0;
      valid <= 1'b0;
      last_cr <= 1'b0;
      strobe <= 1'b0;
      iss <= 1'b0;
      pend <= 1'b0;
    end else begin
      state <= state_next;
      len <= len_next;
      lc <= lc_next;
      last_ld <= last_ld_next;
      dirty <= dirty_next;
      valid <= valid_next;
      last_cr <= last_cr_next;
      strobe <= strobe_next;
      iss <= iss_next;
      pend <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    ra <= ra_next;
    wa <= wa_next;
    first <= first_next;
    seekph <= seekph_next;
    ci <= ci_next;
    line <= line_next;
    n <= n_next;
    col <= col_next;
    cnt <= cnt_next;
    p <= p_next;
    byte_r <= byte_r_next;
    cmd_r <= cmd_r_next;
    dval <= dval_next;
    st_r <= st_r_next;
    val_r <= val_r_next;
  end

  assign tot = (lc == '0) ? LCW'(1) : lc;
  assign result_valid = strobe;
  assign status = st_r;
  assign value = val_r;
  assign total_lines = 14'(tot);
  assign editor_lines = (len == '0) ? 15'd1 : (last_cr ? 15'(lc + 1'b1) : 15'(tot));
  assign modified = dirty;
  assign document_valid = valid;

endmodule
